@@ src/bmmro_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the banked memory mapper with rom overlay
// no dependencies
package bmmro_pkg;

	localparam int BANK_BYTES   = 16384;
	localparam int OFF_W        = 14;
	localparam int BASE_AW      = 16;
	localparam int CMD_AW       = 22;
	localparam int SLOT_SEL_W   = 4;
	localparam int PAGE_SEL_W   = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int QUEUE_DEPTH  = 2;

	typedef enum logic [2:0] {
		REQ_READ       = 3'd0,
		REQ_WRITE      = 3'd1,
		REQ_VIDEO_READ = 3'd2,
		REQ_RAM_CONFIG = 3'd3,
		REQ_SEL_UPPER  = 3'd4,
		REQ_ROM_ENA    = 3'd5,
		REQ_LOAD_LOWER = 3'd6,
		REQ_LOAD_UPPER = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		TGT_BASE = 2'd0,
		TGT_EXT  = 2'd1,
		TGT_LROM = 2'd2,
		TGT_UROM = 2'd3
	} tgt_t;

	// ram configuration numbers with a mapping of their own
	localparam logic [2:0] MAP_IDENT   = 3'd0;
	localparam logic [2:0] MAP_TOP_EXT = 3'd1;
	localparam logic [2:0] MAP_ALL_EXT = 3'd2;
	localparam logic [2:0] MAP_SPLIT   = 3'd3;

	localparam logic [1:0] SRC_RAM   = 2'd0;
	localparam logic [1:0] SRC_LOWER = 2'd1;
	localparam logic [1:0] SRC_UPPER = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_EXT_PAGES     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_PRESENT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_PRESENT = 2'd2;

	localparam logic [1:0] QUARTER_LOW  = 2'd0;
	localparam logic [1:0] QUARTER_ONE  = 2'd1;
	localparam logic [1:0] QUARTER_HIGH = 2'd3;

	// one memory operation handed from front to back
	typedef struct packed {
		logic              write;
		tgt_t              tgt;
		logic [CMD_AW-1:0] addr;
		logic [7:0]        data;
	} cmd_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_wr_t;

endpackage

@@ src/bmmro_ram.sv @@
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies
module bmmro_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/bmmro_queue.sv @@
`timescale 1ns / 1ps
// short command queue between front and back
// depends on bmmro_pkg
module bmmro_queue import bmmro_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/bmmro_front.sv @@
`timescale 1ns / 1ps
// front end: accepts transfers, holds mapping and rom selection state, emits memory commands
// depends on bmmro_pkg
module bmmro_front import bmmro_pkg::*; #(
	parameter int MAX_EXT_PAGES   = 8,
	parameter int UPPER_ROM_SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_wr_t    cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] req_type,
	input  logic [15:0] address,
	input  logic [7:0] write_data,
	input  logic [5:0] ram_page,
	input  logic [2:0] ram_config,
	input  logic [7:0] rom_slot,
	input  logic       enable_upper,
	input  logic       enable_lower,
	input  logic       clearing,
	output logic       push_valid,
	input  logic       push_ready,
	output cmd_t       push_data
);

	logic [3:0]            ext_pages_q;
	logic                  lower_present_q;
	logic [15:0]           upper_present_q;
	logic [2:0]            mode_q;
	logic [PAGE_SEL_W-1:0] page_sel_q;
	logic                  upper_en_q;
	logic                  lower_en_q;
	logic [SLOT_SEL_W-1:0] upper_sel_q;
	logic                  upper_valid_q;

	req_t              req;
	logic              accept;
	logic [1:0]        quarter;
	logic [OFF_W-1:0]  offset;
	logic [6:0]        pages_n;
	logic              use_ext;
	logic [1:0]        bank;
	logic [CMD_AW-1:0] ram_addr;
	logic              slot_in_range;
	logic              slot_present;
	logic              needs_mem;
	cmd_t              cmd;

	assign req     = req_t'(req_type);
	assign quarter = address[15:14];
	assign offset  = address[OFF_W-1:0];
	assign pages_n = (7'(ext_pages_q) > 7'(MAX_EXT_PAGES)) ? 7'(MAX_EXT_PAGES)
	                                                       : 7'(ext_pages_q);
	assign slot_in_range = {1'b0, rom_slot} < 9'(UPPER_ROM_SLOTS);
	assign slot_present  = (rom_slot[7:4] == 4'd0) && upper_present_q[rom_slot[3:0]];

	// cpu view of ram under the current configuration
	always_comb begin
		use_ext = 1'b0;
		bank    = quarter;
		case (mode_q)
			MAP_IDENT: begin
			end
			MAP_TOP_EXT: begin
				use_ext = (quarter == QUARTER_HIGH);
			end
			MAP_ALL_EXT: begin
				use_ext = 1'b1;
			end
			MAP_SPLIT: begin
				if (quarter == QUARTER_ONE) begin
					bank = QUARTER_HIGH;
				end
				use_ext = (quarter == QUARTER_HIGH);
			end
			default: begin
				if (quarter == QUARTER_ONE) begin
					use_ext = 1'b1;
					bank    = mode_q[1:0];
				end
			end
		endcase
		if (use_ext) begin
			ram_addr = CMD_AW'({page_sel_q, bank, offset});
		end else begin
			ram_addr = CMD_AW'({bank, offset});
		end
	end

	always_comb begin
		cmd.write = 1'b0;
		cmd.tgt   = use_ext ? TGT_EXT : TGT_BASE;
		cmd.addr  = ram_addr;
		cmd.data  = write_data;
		needs_mem = 1'b0;
		case (req)
			REQ_READ: begin
				needs_mem = 1'b1;
				if (upper_en_q && quarter == QUARTER_HIGH && upper_valid_q) begin
					cmd.tgt  = TGT_UROM;
					cmd.addr = CMD_AW'({upper_sel_q, offset});
				end else if (lower_en_q && quarter == QUARTER_LOW && lower_present_q) begin
					cmd.tgt  = TGT_LROM;
					cmd.addr = CMD_AW'(offset);
				end
			end
			REQ_WRITE: begin
				needs_mem = 1'b1;
				cmd.write = 1'b1;
			end
			REQ_VIDEO_READ: begin
				needs_mem = 1'b1;
				cmd.tgt   = TGT_BASE;
				cmd.addr  = CMD_AW'(address);
			end
			REQ_LOAD_LOWER: begin
				needs_mem = 1'b1;
				cmd.write = 1'b1;
				cmd.tgt   = TGT_LROM;
				cmd.addr  = CMD_AW'(offset);
			end
			REQ_LOAD_UPPER: begin
				needs_mem = slot_in_range;
				cmd.write = 1'b1;
				cmd.tgt   = TGT_UROM;
				cmd.addr  = CMD_AW'({rom_slot, offset});
			end
			default: begin
			end
		endcase
	end

	assign in_ready   = !clearing && push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = accept && needs_mem;
	assign push_data  = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_pages_q     <= '0;
			lower_present_q <= 1'b0;
			upper_present_q <= '0;
			mode_q          <= MAP_IDENT;
			page_sel_q      <= '0;
			upper_en_q      <= 1'b1;
			lower_en_q      <= 1'b1;
			upper_sel_q     <= '0;
			upper_valid_q   <= 1'b0;
		end else if (cfg.we) begin
			case (cfg.index)
				CFG_EXT_PAGES: begin
					ext_pages_q <= cfg.wdata[3:0];
					mode_q      <= MAP_IDENT;
					page_sel_q  <= '0;
				end
				CFG_LOWER_PRESENT: begin
					lower_present_q <= cfg.wdata[0];
				end
				CFG_UPPER_PRESENT: begin
					upper_present_q <= cfg.wdata;
					if (!cfg.wdata[upper_sel_q]) begin
						upper_valid_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			case (req)
				REQ_RAM_CONFIG: begin
					mode_q     <= MAP_IDENT;
					page_sel_q <= '0;
					if (pages_n != 7'd0) begin
						mode_q <= ram_config;
						if ({1'b0, ram_page} < pages_n) begin
							page_sel_q <= ram_page[PAGE_SEL_W-1:0];
						end
					end
				end
				REQ_SEL_UPPER: begin
					if (slot_in_range && slot_present) begin
						upper_sel_q   <= rom_slot[SLOT_SEL_W-1:0];
						upper_valid_q <= 1'b1;
					end else begin
						upper_sel_q   <= '0;
						upper_valid_q <= upper_present_q[0];
					end
				end
				REQ_ROM_ENA: begin
					upper_en_q <= enable_upper;
					lower_en_q <= enable_lower;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ src/bmmro_back.sv @@
`timescale 1ns / 1ps
// back end: ram clearing pass, memory accesses and the result register
// depends on bmmro_pkg and bmmro_ram
module bmmro_back import bmmro_pkg::*; #(
	parameter int MAX_EXT_PAGES   = 8,
	parameter int UPPER_ROM_SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       clearing,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic [1:0] read_source
);

	localparam int EXT_DEPTH = MAX_EXT_PAGES * 4 * BANK_BYTES;
	localparam int EXT_AW    = $clog2(EXT_DEPTH);
	localparam int UR_DEPTH  = UPPER_ROM_SLOTS * BANK_BYTES;
	localparam int UR_AW     = $clog2(UR_DEPTH);
	localparam int BASE_DEPTH = 4 * BANK_BYTES;

	logic              clearing_q;
	logic [EXT_AW-1:0] clr_q;
	logic              rd_pend_s1;
	tgt_t              rd_tgt_s1;
	logic              out_valid_q;
	logic [7:0]        read_data_q;
	logic [1:0]        read_source_q;

	logic       go;
	logic       issue_rd;
	logic       do_wr;
	logic       base_we, ext_we, lrom_we, urom_we;
	logic [7:0] base_rd, ext_rd, lrom_rd, urom_rd;

	// a read may start only when its byte has a free result register to land in
	assign go        = cmd.write || (!rd_pend_s1 && (!out_valid_q || out_ready));
	assign cmd_ready = !clearing_q && go;
	assign issue_rd  = cmd_valid && cmd_ready && !cmd.write;
	assign do_wr     = cmd_valid && cmd_ready && cmd.write;

	assign base_we = clearing_q || (do_wr && cmd.tgt == TGT_BASE);
	assign ext_we  = clearing_q || (do_wr && cmd.tgt == TGT_EXT);
	assign lrom_we = do_wr && cmd.tgt == TGT_LROM;
	assign urom_we = do_wr && cmd.tgt == TGT_UROM;

	bmmro_ram #(.WIDTH(8), .DEPTH(BASE_DEPTH)) u_base_ram (
		.clk   (clk),
		.we    (base_we),
		.waddr (clearing_q ? clr_q[BASE_AW-1:0] : cmd.addr[BASE_AW-1:0]),
		.wdata (clearing_q ? 8'd0 : cmd.data),
		.raddr (cmd.addr[BASE_AW-1:0]),
		.rdata (base_rd)
	);

	bmmro_ram #(.WIDTH(8), .DEPTH(EXT_DEPTH)) u_ext_ram (
		.clk   (clk),
		.we    (ext_we),
		.waddr (clearing_q ? clr_q : cmd.addr[EXT_AW-1:0]),
		.wdata (clearing_q ? 8'd0 : cmd.data),
		.raddr (cmd.addr[EXT_AW-1:0]),
		.rdata (ext_rd)
	);

	bmmro_ram #(.WIDTH(8), .DEPTH(BANK_BYTES)) u_lower_rom (
		.clk   (clk),
		.we    (lrom_we),
		.waddr (cmd.addr[OFF_W-1:0]),
		.wdata (cmd.data),
		.raddr (cmd.addr[OFF_W-1:0]),
		.rdata (lrom_rd)
	);

	bmmro_ram #(.WIDTH(8), .DEPTH(UR_DEPTH)) u_upper_rom (
		.clk   (clk),
		.we    (urom_we),
		.waddr (cmd.addr[UR_AW-1:0]),
		.wdata (cmd.data),
		.raddr (cmd.addr[UR_AW-1:0]),
		.rdata (urom_rd)
	);

	always_ff @(posedge clk) begin
		if (issue_rd) begin
			rd_tgt_s1 <= cmd.tgt;
		end
		if (rd_pend_s1) begin
			case (rd_tgt_s1)
				TGT_EXT: begin
					read_data_q   <= ext_rd;
					read_source_q <= SRC_RAM;
				end
				TGT_LROM: begin
					read_data_q   <= lrom_rd;
					read_source_q <= SRC_LOWER;
				end
				TGT_UROM: begin
					read_data_q   <= urom_rd;
					read_source_q <= SRC_UPPER;
				end
				default: begin
					read_data_q   <= base_rd;
					read_source_q <= SRC_RAM;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_q       <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == EXT_AW'(EXT_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			rd_pend_s1 <= issue_rd;
			if (rd_pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign clearing    = clearing_q;
	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign read_source = read_source_q;

endmodule

@@ src/banked_memory_mapper_rom_overlay_unit.sv @@
`timescale 1ns / 1ps
// top level of the banked memory mapper with rom overlay
// depends on bmmro_pkg, bmmro_front, bmmro_queue, bmmro_back
//
// cpu bus accesses and control items arrive as transfers on the in channel; reads and
// video reads return one byte and its source on the out channel, everything else returns
// nothing. after reset the block first zeroes base and extended ram, one byte a cycle,
// and takes no transfer until that pass ends (config writes are taken throughout). a
// read passes through the registered ram read and then into the result register; the
// back end holds a single outstanding read and takes no new read until the last one has
// landed and the result register is free. the command queue holds up to two memory
// commands, so the front end, which keeps the mapping and rom selection state, keeps
// taking transfers while a result waits until that queue is full. configuration is
// written through cfg_we / cfg_index / cfg_wdata while the block is idle; the user is
// bound to this, the block itself does not enforce it.
module banked_memory_mapper_rom_overlay_unit import bmmro_pkg::*; #(
	parameter int MAX_EXT_PAGES   = 8,
	parameter int UPPER_ROM_SLOTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            req_type,
	input  logic [15:0]           address,
	input  logic [7:0]            write_data,
	input  logic [5:0]            ram_page,
	input  logic [2:0]            ram_config,
	input  logic [7:0]            rom_slot,
	input  logic                  enable_upper,
	input  logic                  enable_lower,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            read_data,
	output logic [1:0]            read_source
);

	cfg_wr_t cfg;
	logic    clearing;
	logic    push_valid;
	logic    push_ready;
	cmd_t    push_data;
	logic    pop_valid;
	logic    pop_ready;
	cmd_t    pop_data;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.wdata = cfg_wdata;

	// front: classify each transfer, update mapping state, build memory commands
	bmmro_front #(
		.MAX_EXT_PAGES   (MAX_EXT_PAGES),
		.UPPER_ROM_SLOTS (UPPER_ROM_SLOTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.address      (address),
		.write_data   (write_data),
		.ram_page     (ram_page),
		.ram_config   (ram_config),
		.rom_slot     (rom_slot),
		.enable_upper (enable_upper),
		.enable_lower (enable_lower),
		.clearing     (clearing),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	// two-entry command queue decouples the two halves
	bmmro_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back: memories, clearing pass and result register
	bmmro_back #(
		.MAX_EXT_PAGES   (MAX_EXT_PAGES),
		.UPPER_ROM_SLOTS (UPPER_ROM_SLOTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (pop_valid),
		.cmd_ready   (pop_ready),
		.cmd         (pop_data),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_data   (read_data),
		.read_source (read_source)
	);

	// no transfer gets in while the ram clearing pass runs
	assert property (@(posedge clk) disable iff (!arst_n) clearing |-> !in_ready)
		else $error("transfer accepted during ram clearing");

	// nothing is queued for the back end while it is still clearing
	assert property (@(posedge clk) disable iff (!arst_n) clearing |-> !pop_valid)
		else $error("command queued during ram clearing");

	// a result only ever names ram, lower rom or upper rom
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (read_source == SRC_RAM || read_source == SRC_LOWER ||
		               read_source == SRC_UPPER))
		else $error("bad read source");

endmodule

@@ tb/banked_memory_mapper_rom_overlay_unit_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for the banked memory mapper with rom overlay
// depends on bmmro_pkg and banked_memory_mapper_rom_overlay_unit
module banked_memory_mapper_rom_overlay_unit_tb;
	import bmmro_pkg::*;

	localparam int EXT_PAGES_MAX   = 8;
	localparam int ROM_SLOTS       = 16;
	localparam int BASE_BYTES      = 4 * BANK_BYTES;
	localparam int EXT_BYTES       = EXT_PAGES_MAX * 4 * BANK_BYTES;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 128;
	// cycles allowed for a write still in the back end after the last read result
	localparam int DRAIN           = 16;
	// length of the long receiver hold-off that fills the front end queue
	localparam int HOLD_CYCLES     = 200;

	// one bus access or control item as it crosses the in channel
	typedef struct {
		req_t       kind;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [5:0]  page;
		logic [2:0]  rcfg;
		logic [7:0]  slot;
		bit          en_up;
		bit          en_lo;
	} bus_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] src;
	} read_res_t;

	// directed table row: a register write or an item, with an optional typed-in result
	typedef struct {
		bit                    is_reg_write;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [15:0]           reg_val;
		bus_item_t             item;
		bit                    typed;
		read_res_t             want;
	} plan_row_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic [2:0]            req_type     = REQ_READ;
	logic [15:0]           address      = '0;
	logic [7:0]            write_data   = '0;
	logic [5:0]            ram_page     = '0;
	logic [2:0]            ram_config   = '0;
	logic [7:0]            rom_slot     = '0;
	logic                  enable_upper = 1'b0;
	logic                  enable_lower = 1'b0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [7:0]            read_data;
	logic [1:0]            read_source;

	banked_memory_mapper_rom_overlay_unit #(
		.MAX_EXT_PAGES  (EXT_PAGES_MAX),
		.UPPER_ROM_SLOTS(ROM_SLOTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.address     (address),
		.write_data  (write_data),
		.ram_page    (ram_page),
		.ram_config  (ram_config),
		.rom_slot    (rom_slot),
		.enable_upper(enable_upper),
		.enable_lower(enable_lower),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_data   (read_data),
		.read_source (read_source)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------------------------
	// mapper state as the bench sees it
	// ---------------------------------------------------------------------------------
	// base ram at 0..65535, extended ram right behind it; both start cleared
	bit [7:0]   ram_mem  [BASE_BYTES + EXT_BYTES];
	bit [7:0]   lrom_mem [BANK_BYTES];
	bit         lrom_ok  [BANK_BYTES];
	bit [7:0]   urom_mem [ROM_SLOTS * BANK_BYTES];
	bit         urom_ok  [ROM_SLOTS * BANK_BYTES];
	// last loaded offset per rom image, -1 while nothing is loaded
	int         lrom_last = -1;
	int         urom_last [ROM_SLOTS];

	logic [2:0] map_mode     = MAP_IDENT;
	logic [4:0] map_page     = '0;
	bit         upper_on     = 1'b1;
	bit         lower_on     = 1'b1;
	logic [3:0] upper_slot   = '0;
	bit         upper_ok     = 1'b0;
	logic [3:0] pages_fitted = '0;
	bit         lower_fitted = 1'b0;
	logic [15:0] upper_fitted = '0;

	read_res_t  pending_reads [$];
	plan_row_t  plan [$];
	int         mismatches = 0;
	bit         quiet      = 1'b0;
	bit         hold_req   = 1'b0;
	int         hold_left  = 0;

	task automatic report_mismatch(string what);
		if (mismatches < 50)
			$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// index into ram_mem of the ram byte that the cpu sees at a
	function automatic int ram_index(logic [15:0] a);
		logic [1:0] q;
		int         bank;
		int         ext;
		q    = a[15:14];
		bank = q;
		ext  = -1;
		if (map_mode[2]) begin
			// configurations 4..7 swap one extended bank into the second quarter
			if (q == QUARTER_ONE)
				ext = map_mode[1:0];
		end else begin
			case (map_mode)
				MAP_TOP_EXT: begin
					if (q == QUARTER_HIGH)
						ext = QUARTER_HIGH;
				end
				MAP_ALL_EXT: ext = q;
				MAP_SPLIT: begin
					if (q == QUARTER_ONE)
						bank = QUARTER_HIGH;
					if (q == QUARTER_HIGH)
						ext = QUARTER_HIGH;
				end
				default: ;
			endcase
		end
		if (ext >= 0)
			return BASE_BYTES + ((map_page * 4 + ext) * BANK_BYTES + a[13:0]) % EXT_BYTES;
		return bank * BANK_BYTES + a[13:0];
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		case (idx)
			CFG_EXT_PAGES: begin
				// a new page count puts the mapping back to identity
				pages_fitted = val[3:0];
				map_mode     = MAP_IDENT;
				map_page     = '0;
			end
			CFG_LOWER_PRESENT: lower_fitted = val[0];
			CFG_UPPER_PRESENT: begin
				// pulling the selected image drops the selection until the next selection
				upper_fitted = val;
				if (upper_ok && !upper_fitted[upper_slot])
					upper_ok = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// updates the state for one accepted item; returns 1 when a read result follows
	function automatic bit predict_access(bus_item_t it, output read_res_t res);
		logic [1:0] q;
		int         off;
		int         pages;
		q   = it.addr[15:14];
		off = it.addr[13:0];
		res = '0;
		case (it.kind)
			REQ_READ: begin
				if (upper_on && q == QUARTER_HIGH && upper_ok) begin
					res.data = urom_mem[upper_slot * BANK_BYTES + off];
					res.src  = SRC_UPPER;
				end else if (lower_on && q == QUARTER_LOW && lower_fitted) begin
					res.data = lrom_mem[off];
					res.src  = SRC_LOWER;
				end else begin
					res.data = ram_mem[ram_index(it.addr)];
					res.src  = SRC_RAM;
				end
				return 1'b1;
			end
			REQ_WRITE: ram_mem[ram_index(it.addr)] = it.data;
			REQ_VIDEO_READ: begin
				// video always sees base ram, no rom and no banking
				res.data = ram_mem[it.addr];
				res.src  = SRC_RAM;
				return 1'b1;
			end
			REQ_RAM_CONFIG: begin
				pages    = (pages_fitted > EXT_PAGES_MAX) ? EXT_PAGES_MAX : pages_fitted;
				map_mode = MAP_IDENT;
				map_page = '0;
				// without extended ram the mapping stays identity;
				// a page that is not installed falls back to page 0
				if (pages != 0) begin
					map_page = (it.page >= pages) ? 5'd0 : it.page[4:0];
					map_mode = it.rcfg;
				end
			end
			REQ_SEL_UPPER: begin
				if (it.slot < ROM_SLOTS && upper_fitted[it.slot[3:0]]) begin
					upper_slot = it.slot[3:0];
					upper_ok   = 1'b1;
				end else begin
					upper_slot = '0;
					upper_ok   = upper_fitted[0];
				end
			end
			REQ_ROM_ENA: begin
				upper_on = it.en_up;
				lower_on = it.en_lo;
			end
			REQ_LOAD_LOWER: begin
				lrom_mem[off] = it.data;
				lrom_ok[off]  = 1'b1;
				lrom_last     = off;
			end
			REQ_LOAD_UPPER: begin
				// loads to slots beyond the fitted range are dropped
				if (it.slot < ROM_SLOTS) begin
					urom_mem[it.slot * BANK_BYTES + off] = it.data;
					urom_ok[it.slot * BANK_BYTES + off]  = 1'b1;
					urom_last[it.slot]                   = off;
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------------------
	function automatic bus_item_t mk_item(req_t k, logic [15:0] a = '0, logic [7:0] d = '0,
			logic [5:0] pg = '0, logic [2:0] rc = '0, logic [7:0] sl = '0,
			bit eu = 1'b1, bit el = 1'b1);
		bus_item_t it;
		it.kind  = k;
		it.addr  = a;
		it.data  = d;
		it.page  = pg;
		it.rcfg  = rc;
		it.slot  = sl;
		it.en_up = eu;
		it.en_lo = el;
		return it;
	endfunction

	function automatic plan_row_t op_row(bus_item_t it, bit typed = 1'b0,
			logic [7:0] d = '0, logic [1:0] s = SRC_RAM);
		plan_row_t r;
		r.is_reg_write = 1'b0;
		r.reg_idx      = '0;
		r.reg_val      = '0;
		r.item         = it;
		r.typed        = typed;
		r.want.data    = d;
		r.want.src     = s;
		return r;
	endfunction

	function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		plan_row_t r;
		r              = op_row(mk_item(REQ_READ));
		r.is_reg_write = 1'b1;
		r.reg_idx      = idx;
		r.reg_val      = val;
		return r;
	endfunction

	// offsets cluster at both ends of a bank so writes, loads and reads meet
	function automatic logic [13:0] pick_offset();
		logic [13:0] off;
		if ($urandom_range(99) < 50) begin
			off = 14'($urandom_range(0, 15));
			if ($urandom_range(1))
				off = off | 14'h3FF0;
		end else begin
			off = 14'($urandom());
		end
		return off;
	endfunction

	// a rom byte never loaded has no defined value: a read that would land on one
	// is moved to a loaded offset of the same image, or else out to quarter one
	function automatic logic [15:0] steer_read(logic [15:0] a);
		int off;
		off = a[13:0];
		if (upper_on && a[15:14] == QUARTER_HIGH && upper_ok
				&& !urom_ok[upper_slot * BANK_BYTES + off]) begin
			if (urom_last[upper_slot] >= 0)
				a[13:0] = 14'(urom_last[upper_slot]);
			else
				a[15:14] = QUARTER_ONE;
		end else if (lower_on && a[15:14] == QUARTER_LOW && lower_fitted && !lrom_ok[off]) begin
			if (lrom_last >= 0)
				a[13:0] = 14'(lrom_last);
			else
				a[15:14] = QUARTER_ONE;
		end
		return a;
	endfunction

	function automatic bus_item_t random_item();
		bus_item_t it;
		int        pick;
		pick     = $urandom_range(99);
		it       = mk_item(REQ_READ);
		it.addr  = {2'($urandom()), pick_offset()};
		it.data  = 8'($urandom());
		it.page  = ($urandom_range(99) < 60) ? 6'($urandom_range(0, 8)) : 6'($urandom());
		it.rcfg  = 3'($urandom());
		it.slot  = ($urandom_range(99) < 60) ? 8'($urandom_range(0, 15)) : 8'($urandom());
		it.en_up = ($urandom_range(99) < 75) ? 1'b1 : 1'($urandom());
		it.en_lo = ($urandom_range(99) < 75) ? 1'b1 : 1'($urandom());
		if (pick < 32)
			it.kind = REQ_READ;
		else if (pick < 52)
			it.kind = REQ_WRITE;
		else if (pick < 62)
			it.kind = REQ_VIDEO_READ;
		else if (pick < 70)
			it.kind = REQ_RAM_CONFIG;
		else if (pick < 77)
			it.kind = REQ_SEL_UPPER;
		else if (pick < 83)
			it.kind = REQ_ROM_ENA;
		else if (pick < 91)
			it.kind = REQ_LOAD_LOWER;
		else
			it.kind = REQ_LOAD_UPPER;
		if (it.kind == REQ_READ)
			it.addr = steer_read(it.addr);
		return it;
	endfunction

	// offers one item, holds it until the transfer, then books its result
	task automatic send_item(bus_item_t it, bit typed, read_res_t want);
		read_res_t model_res;
		bit        has_res;
		if (!quiet && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= it.kind;
		address      <= it.addr;
		write_data   <= it.data;
		ram_page     <= it.page;
		ram_config   <= it.rcfg;
		rom_slot     <= it.slot;
		enable_upper <= it.en_up;
		enable_lower <= it.en_lo;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		has_res = predict_access(it, model_res);
		if (has_res)
			pending_reads.push_back(typed ? want : model_res);
	endtask

	// stop offering, let every booked read return and the last write drain
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		apply_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------------------------
	// result side: random back-pressure plus one long hold-off on request
	// ---------------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_req  <= 1'b0;
		end else begin
			out_ready <= quiet || ($urandom_range(99) >= 25);
		end
	end

	// every result transfer is matched against the oldest booked read
	always @(posedge clk) begin
		read_res_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reads.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: data %02h source %0d",
					read_data, read_source));
			end else begin
				exp_res = pending_reads.pop_front();
				if (read_data !== exp_res.data)
					report_mismatch($sformatf("read_data %02h, expected %02h",
						read_data, exp_res.data));
				if (read_source !== exp_res.src)
					report_mismatch($sformatf("read_source %0d, expected %0d",
						read_source, exp_res.src));
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------------------------
	initial begin
		foreach (urom_last[i])
			urom_last[i] = -1;

		// defaults after reset: no extended pages, no rom images fitted
		plan.push_back(op_row(mk_item(REQ_READ, 16'h0000), 1'b1, 8'h00, SRC_RAM));
		plan.push_back(op_row(mk_item(REQ_READ, 16'hFFFF), 1'b1, 8'h00, SRC_RAM));
		plan.push_back(op_row(mk_item(REQ_WRITE, 16'hFFFF, 8'hFF)));
		plan.push_back(op_row(mk_item(REQ_READ, 16'hFFFF), 1'b1, 8'hFF, SRC_RAM));
		// no extended ram: a ram configuration keeps the identity mapping
		plan.push_back(op_row(mk_item(REQ_RAM_CONFIG, 16'h0000, 8'h00, 6'd63, 3'd7)));
		plan.push_back(op_row(mk_item(REQ_WRITE, 16'h4000, 8'hA5)));
		plan.push_back(op_row(mk_item(REQ_VIDEO_READ, 16'h4000), 1'b1, 8'hA5, SRC_RAM));
		// page count above the fitted maximum, both rom images fitted
		plan.push_back(reg_row(CFG_EXT_PAGES, 16'h000F));
		plan.push_back(reg_row(CFG_LOWER_PRESENT, 16'h0001));
		plan.push_back(reg_row(CFG_UPPER_PRESENT, 16'hFFFF));
		plan.push_back(op_row(mk_item(REQ_LOAD_LOWER, 16'h0000, 8'h5A)));
		plan.push_back(op_row(mk_item(REQ_LOAD_LOWER, 16'hFFFF, 8'hC3)));
		plan.push_back(op_row(mk_item(REQ_LOAD_UPPER, 16'h3FFF, 8'h81, 6'd0, 3'd0, 8'd15)));
		// load to a slot out of range is dropped
		plan.push_back(op_row(mk_item(REQ_LOAD_UPPER, 16'h0000, 8'h77, 6'd0, 3'd0, 8'd255)));
		plan.push_back(op_row(mk_item(REQ_LOAD_UPPER, 16'hC000, 8'h11, 6'd0, 3'd0, 8'd0)));
		plan.push_back(op_row(mk_item(REQ_SEL_UPPER, 16'h0000, 8'h00, 6'd0, 3'd0, 8'd15)));
		plan.push_back(op_row(mk_item(REQ_READ, 16'hFFFF), 1'b1, 8'h81, SRC_UPPER));
		plan.push_back(op_row(mk_item(REQ_READ, 16'h3FFF), 1'b1, 8'hC3, SRC_LOWER));
		plan.push_back(op_row(mk_item(REQ_VIDEO_READ, 16'hFFFF), 1'b1, 8'hFF, SRC_RAM));
		plan.push_back(op_row(mk_item(REQ_RAM_CONFIG, 16'h0000, 8'h00, 6'd7, MAP_ALL_EXT)));
		plan.push_back(op_row(mk_item(REQ_WRITE, 16'h8000, 8'h3C)));
		plan.push_back(op_row(mk_item(REQ_READ, 16'h8000)));
		// out of range selection falls back to slot 0
		plan.push_back(op_row(mk_item(REQ_SEL_UPPER, 16'h0000, 8'h00, 6'd0, 3'd0, 8'd200)));
		plan.push_back(op_row(mk_item(REQ_READ, 16'hC000), 1'b1, 8'h11, SRC_UPPER));
		plan.push_back(op_row(mk_item(REQ_ROM_ENA, 16'h0000, 8'h00, 6'd0, 3'd0, 8'd0,
			1'b0, 1'b0)));
		plan.push_back(op_row(mk_item(REQ_READ, 16'h0000)));
		// removing slot 0 drops the selection even once the overlay is back on
		plan.push_back(reg_row(CFG_UPPER_PRESENT, 16'hFFFE));
		plan.push_back(op_row(mk_item(REQ_ROM_ENA, 16'h0000, 8'h00, 6'd0, 3'd0, 8'd0,
			1'b1, 1'b1)));
		plan.push_back(op_row(mk_item(REQ_READ, 16'hC000)));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the first transfer also waits out the ram clearing pass after reset
		foreach (plan[i]) begin
			if (plan[i].is_reg_write) begin
				settle();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_item(plan[i].item, plan[i].typed, plan[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			logic [15:0] pages_v;
			logic [15:0] lower_v;
			logic [15:0] upper_v;
			case (ph)
				0: begin
					pages_v = 16'd0;
					lower_v = 16'd1;
					upper_v = 16'hFFFF;
				end
				1: begin
					pages_v = 16'd15;
					lower_v = 16'd0;
					upper_v = 16'h0000;
				end
				2: begin
					pages_v = 16'd8;
					lower_v = 16'd1;
					upper_v = 16'($urandom());
				end
				3: begin
					pages_v = 16'd1;
					lower_v = 16'd1;
					upper_v = 16'hFFFF;
				end
				6: begin
					pages_v = 16'd2;
					lower_v = 16'd1;
					upper_v = 16'h0001;
				end
				default: begin
					pages_v = 16'($urandom_range(0, 15));
					lower_v = 16'($urandom_range(0, 1));
					upper_v = 16'($urandom());
				end
			endcase
			settle();
			write_reg(CFG_UPPER_PRESENT, upper_v);
			write_reg(CFG_EXT_PAGES, pages_v);
			write_reg(CFG_LOWER_PRESENT, lower_v);
			// one whole phase runs without any idling on either side
			quiet = (ph == 5);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// receiver stalls for a long stretch while items keep coming
				if (ph == 3 && n == 40)
					hold_req = 1'b1;
				send_item(random_item(), 1'b0, '0);
			end
		end

		settle();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// run limit: clearing pass plus the whole item stream with room to spare
	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
